// ===== hw/rtl/shlo_pkg.sv =====
// Shared types, constants and fixed-point helpers for the smoothed hinge loss unit.
package shlo_pkg;

   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int CFG_W       = 31;
   localparam int WIDE_W      = DATA_W + 2;
   localparam int DEN_W       = DATA_W + 1;
   localparam int PROD_MAG_W  = 2 * DATA_W - FRAC_W;
   localparam int DIV_STEPS   = DATA_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CFG_W-1:0] SMOOTHING_RESET = 31'd65536;
   localparam logic [CFG_W-1:0] PROX_RESET      = 31'd65536;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam word_type ONE_Q     = 32'sh0001_0000;
   localparam word_type NEG_ONE_Q = 32'shffff_0000;
   localparam word_type MAX_Q     = 32'sh7fff_ffff;
   localparam word_type MIN_Q     = 32'sh8000_0000;
   localparam word_type ZERO_Q    = 32'sh0000_0000;

   typedef enum logic [1:0] {
      OP_LOSS  = 2'd0,
      OP_DERIV = 2'd1,
      OP_CONJ  = 2'd2,
      OP_PROX  = 2'd3
   } op_type;

   typedef enum logic {
      REG_SMOOTHING_WIDTH = 1'b0,
      REG_PROX_STEP       = 1'b1
   } csr_index_type;

   typedef struct packed {
      word_type val;
      logic     sat;
   } sat_word_type;

   // classified item handed from the front to the back
   typedef struct packed {
      op_type   op;
      word_type y;
      word_type p;
      logic     sat;
   } item_type;

   // per-item context carried alongside the divider
   typedef struct packed {
      op_type   op;
      word_type y;
      word_type p;
      word_type hsub;
      word_type m4;
      logic     lt;
      logic     ge;
      logic     gt;
      logic     lt2;
      logic     sat;
   } side_type;

   function automatic wide_type ext34(input word_type a);
      return {{2{a[DATA_W-1]}}, a};
   endfunction

   function automatic sat_word_type clamp34(input wide_type v);
      sat_word_type r;
      if (v > ext34(MAX_Q)) begin
         r.val = MAX_Q;
         r.sat = 1'b1;
      end else if (v < ext34(MIN_Q)) begin
         r.val = MIN_Q;
         r.sat = 1'b1;
      end else begin
         r.val = v[DATA_W-1:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] mag(input word_type a);
      logic [DATA_W-1:0] u;
      u = a;
      return a[DATA_W-1] ? (~u + 32'd1) : u;
   endfunction

   function automatic sat_word_type to_signed_sat(input logic neg,
                                                  input logic [PROD_MAG_W-1:0] m);
      sat_word_type r;
      r.sat = 1'b0;
      if (neg) begin
         if (m > 48'h0000_8000_0000) begin
            r.val = MIN_Q;
            r.sat = 1'b1;
         end else begin
            r.val = ~m[DATA_W-1:0] + 32'd1;
         end
      end else begin
         if (m > 48'h0000_7fff_ffff) begin
            r.val = MAX_Q;
            r.sat = 1'b1;
         end else begin
            r.val = m[DATA_W-1:0];
         end
      end
      return r;
   endfunction

   // truncating Q multiply with saturation
   function automatic sat_word_type smul(input word_type a, input word_type b);
      logic [DATA_W-1:0]   ma;
      logic [DATA_W-1:0]   mb;
      logic [2*DATA_W-1:0] prod;
      ma   = mag(a);
      mb   = mag(b);
      prod = 64'(ma) * 64'(mb);
      return to_signed_sat(a[DATA_W-1] ^ b[DATA_W-1], prod[2*DATA_W-1:FRAC_W]);
   endfunction

endpackage

// ===== hw/rtl/shlo_req_if.sv =====
// Request channel: operation, margin and label with valid/ready.
interface shlo_req_if
   import shlo_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   word_type    margin_value;
   word_type    label_value;

   modport source (output valid, operation, margin_value, label_value, input ready);
   modport sink   (input valid, operation, margin_value, label_value, output ready);
endinterface

// ===== hw/rtl/shlo_rsp_if.sv =====
// Response channel: result value and flags with valid/ready.
interface shlo_rsp_if
   import shlo_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type result_value;
   logic     out_of_domain;
   logic     saturated;

   modport source (output valid, result_value, out_of_domain, saturated, input ready);
   modport sink   (input valid, result_value, out_of_domain, saturated, output ready);
endinterface

// ===== hw/rtl/shlo_front.sv =====
// Front end: accepts requests, forms the label-margin product and classifies the item.
module shlo_front
   import shlo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   shlo_req_if.sink   req,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   logic         fr_v_ff;
   item_type     fr_item_ff;
   item_type     fr_item_in;
   sat_word_type mp;
   logic         take;

   assign req.ready = !fr_v_ff || !q_full;
   assign take      = req.valid && req.ready;
   assign q_push    = fr_v_ff && !q_full;
   assign q_item    = fr_item_ff;

   always_comb begin
      mp             = smul(req.label_value, req.margin_value);
      fr_item_in.op  = op_type'(req.operation);
      fr_item_in.y   = req.label_value;
      fr_item_in.p   = mp.val;
      fr_item_in.sat = mp.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_v_ff <= 1'b0;
      end else if (take) begin
         fr_v_ff <= 1'b1;
      end else if (q_push) begin
         fr_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         fr_item_ff <= fr_item_in;
      end
   end

endmodule

// ===== hw/rtl/shlo_queue.sv =====
// Small FIFO between the front end and the arithmetic back end.
module shlo_queue
   import shlo_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type head,
   output logic     head_valid
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;

   assign full       = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/shlo_div.sv =====
// Pipelined restoring divider: floor(|num| * 2^FRAC / den), one quotient bit per stage.
module shlo_div
   import shlo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_v,
   input  word_type          num,
   input  logic [DEN_W-1:0]  den,
   input  side_type          in_side,
   output logic              out_v,
   output logic [DATA_W-1:0] out_quo,
   output logic              out_neg,
   output logic              out_ovf,
   output side_type          out_side
);

   logic                 pre_v_ff;
   logic                 pre_neg_ff;
   logic                 pre_ovf_ff;
   logic [WIDE_W-1:0]    pre_r_ff;
   logic [DATA_W-1:0]    pre_sh_ff;
   logic [DEN_W-1:0]     pre_d_ff;
   side_type             pre_side_ff;

   logic [DATA_W-1:0]    n_mag;
   logic                 ovf_in;

   logic                 st_v_ff    [DIV_STEPS];
   logic                 st_neg_ff  [DIV_STEPS];
   logic                 st_ovf_ff  [DIV_STEPS];
   logic [WIDE_W-1:0]    st_r_ff    [DIV_STEPS];
   logic [DATA_W-1:0]    st_sh_ff   [DIV_STEPS];
   logic [DATA_W-1:0]    st_q_ff    [DIV_STEPS];
   logic [DEN_W-1:0]     st_d_ff    [DIV_STEPS];
   side_type             st_side_ff [DIV_STEPS];

   logic [WIDE_W-1:0]    st_r_in    [DIV_STEPS];
   logic [DATA_W-1:0]    st_sh_in   [DIV_STEPS];
   logic [DATA_W-1:0]    st_q_in    [DIV_STEPS];

   always_comb begin
      n_mag = mag(num);
      if (den == '0) begin
         ovf_in = n_mag != '0;
      end else begin
         ovf_in = {17'd0, n_mag} >= {den, 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_v_ff <= 1'b0;
      end else if (adv) begin
         pre_v_ff <= in_v;
      end
   end

   // zero divisor: a zero dividend gives zero, any other one is flagged as overflow
   always_ff @(posedge clock) begin
      if (adv) begin
         pre_neg_ff  <= num[DATA_W-1];
         pre_ovf_ff  <= ovf_in;
         pre_r_ff    <= {18'd0, n_mag[DATA_W-1:FRAC_W]};
         pre_sh_ff   <= {n_mag[FRAC_W-1:0], 16'd0};
         pre_d_ff    <= (den == '0) ? DEN_W'(1) : den;
         pre_side_ff <= in_side;
      end
   end

   always_comb begin
      for (int i = 0; i < DIV_STEPS; i++) begin
         logic [WIDE_W-1:0] r_src;
         logic [DATA_W-1:0] sh_src;
         logic [DATA_W-1:0] q_src;
         logic [DEN_W-1:0]  d_src;
         logic [WIDE_W-1:0] r_shift;
         if (i == 0) begin
            r_src  = pre_r_ff;
            sh_src = pre_sh_ff;
            q_src  = '0;
            d_src  = pre_d_ff;
         end else begin
            r_src  = st_r_ff[i-1];
            sh_src = st_sh_ff[i-1];
            q_src  = st_q_ff[i-1];
            d_src  = st_d_ff[i-1];
         end
         r_shift     = {r_src[WIDE_W-2:0], sh_src[DATA_W-1]};
         st_sh_in[i] = {sh_src[DATA_W-2:0], 1'b0};
         if (r_shift >= {1'b0, d_src}) begin
            st_r_in[i] = r_shift - {1'b0, d_src};
            st_q_in[i] = {q_src[DATA_W-2:0], 1'b1};
         end else begin
            st_r_in[i] = r_shift;
            st_q_in[i] = {q_src[DATA_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            st_v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         st_v_ff[0] <= pre_v_ff;
         for (int i = 1; i < DIV_STEPS; i++) begin
            st_v_ff[i] <= st_v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_neg_ff[0]  <= pre_neg_ff;
         st_ovf_ff[0]  <= pre_ovf_ff;
         st_d_ff[0]    <= pre_d_ff;
         st_side_ff[0] <= pre_side_ff;
         for (int i = 1; i < DIV_STEPS; i++) begin
            st_neg_ff[i]  <= st_neg_ff[i-1];
            st_ovf_ff[i]  <= st_ovf_ff[i-1];
            st_d_ff[i]    <= st_d_ff[i-1];
            st_side_ff[i] <= st_side_ff[i-1];
         end
         for (int i = 0; i < DIV_STEPS; i++) begin
            st_r_ff[i]  <= st_r_in[i];
            st_sh_ff[i] <= st_sh_in[i];
            st_q_ff[i]  <= st_q_in[i];
         end
      end
   end

   assign out_v    = st_v_ff[DIV_STEPS-1];
   assign out_quo  = st_q_ff[DIV_STEPS-1];
   assign out_neg  = st_neg_ff[DIV_STEPS-1];
   assign out_ovf  = st_ovf_ff[DIV_STEPS-1];
   assign out_side = st_side_ff[DIV_STEPS-1];

endmodule

// ===== hw/rtl/shlo_back.sv =====
// Back end: per-operation arithmetic pipeline with shared divider and output register.
module shlo_back
   import shlo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] delta,
   input  logic [CFG_W-1:0] sigma,
   input  item_type         head,
   input  logic             head_valid,
   output logic             head_pop,
   shlo_rsp_if.source       rsp
);

   logic         adv;
   word_type     delta_w;
   word_type     sigma_w;
   word_type     half_w;

   logic         g_v_ff;
   op_type       g_op_ff;
   word_type     g_val_ff;
   logic         g_ood_ff;
   logic         g_sat_ff;

   // stage 1
   logic         s1_v_ff;
   item_type     s1_item_ff;
   item_type     s1_item_in;
   word_type     s1_ps_ff;
   sat_word_type ps_c;

   // stage 2
   logic             s2_v_ff;
   side_type         s2_side_ff;
   word_type         s2_t_ff;
   word_type         s2_num_ff;
   logic [DEN_W-1:0] s2_den_ff;
   side_type         s2_side_in;
   sat_word_type     t_c;
   sat_word_type     num3_c;
   sat_word_type     den_c;
   word_type         s2_num_in;
   logic [DEN_W-1:0] s2_den_in;

   // stage 3
   logic             s3_v_ff;
   side_type         s3_side_ff;
   word_type         s3_sq_ff;
   word_type         s3_num_ff;
   logic [DEN_W-1:0] s3_den_ff;
   side_type         s3_side_in;
   sat_word_type     sq_c;

   // divider feed
   sat_word_type     m4_c;
   side_type         div_side_in;
   word_type         div_num_in;

   logic              dv_v;
   logic [DATA_W-1:0] dv_quo;
   logic              dv_neg;
   logic              dv_ovf;
   side_type          dv_side;

   // stage F
   logic         f_v_ff;
   op_type       f_op_ff;
   word_type     f_y_ff;
   word_type     f_val_ff;
   logic         f_ood_ff;
   logic         f_sat_ff;
   word_type     f_val_in;
   logic         f_ood_in;
   logic         f_sat_in;
   sat_word_type dres;
   sat_word_type sa_c;

   // output stage
   sat_word_type gm_c;
   word_type     g_val_in;
   logic         g_sat_in;

   assign delta_w  = {1'b0, delta};
   assign sigma_w  = {1'b0, sigma};
   assign half_w   = {2'b0, delta[CFG_W-1:1]};
   assign adv      = !g_v_ff || rsp.ready;
   assign head_pop = adv && head_valid;

   // stage 1: sigma * delta for the prox denominator
   always_comb ps_c = smul(sigma_w, delta_w);

   always_comb begin
      s1_item_in     = head;
      s1_item_in.sat = head.sat || (head.op == OP_PROX && ps_c.sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= s1_item_in;
         s1_ps_ff   <= ps_c.val;
      end
   end

   // stage 2: compares and add/subtract steps
   always_comb begin
      t_c    = clamp34(ext34(ONE_Q) - ext34(s1_item_ff.p));
      num3_c = clamp34(ext34(s1_item_ff.p) - ext34(sigma_w));
      den_c  = clamp34(ext34(ONE_Q) + ext34(s1_ps_ff));

      s2_side_in.op   = s1_item_ff.op;
      s2_side_in.y    = s1_item_ff.y;
      s2_side_in.p    = s1_item_ff.p;
      s2_side_in.lt   = s1_item_ff.p < ONE_Q;
      s2_side_in.ge   = t_c.val >= delta_w;
      s2_side_in.gt   = s1_item_ff.p > ONE_Q;
      s2_side_in.lt2  = ext34(s1_item_ff.p) < (ext34(ONE_Q) - ext34(delta_w));
      s2_side_in.hsub = t_c.val - half_w;
      s2_side_in.m4   = ZERO_Q;
      s2_side_in.sat  = s1_item_ff.sat;

      unique case (s1_item_ff.op)
         OP_LOSS: begin
            s2_num_in = s1_item_ff.p;
            s2_den_in = {1'b0, delta, 1'b0};
            s2_side_in.sat = s1_item_ff.sat || (s2_side_in.lt && t_c.sat);
         end
         OP_DERIV: begin
            s2_num_in = s1_item_ff.p - ONE_Q;
            s2_den_in = {2'b0, delta};
         end
         OP_CONJ: begin
            s2_num_in = s1_item_ff.p;
            s2_den_in = {2'b0, delta};
         end
         OP_PROX: begin
            s2_num_in = num3_c.val;
            s2_den_in = {1'b0, den_c.val};
            s2_side_in.sat = s1_item_ff.sat || num3_c.sat || den_c.sat;
         end
         default: begin
            s2_num_in = s1_item_ff.p;
            s2_den_in = {2'b0, delta};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_side_ff <= s2_side_in;
         s2_t_ff    <= t_c.val;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
      end
   end

   // stage 3: square of t (loss) or p (conjugate)
   always_comb begin
      sq_c = smul((s2_side_ff.op == OP_LOSS) ? s2_t_ff : s2_side_ff.p,
                  (s2_side_ff.op == OP_LOSS) ? s2_t_ff : s2_side_ff.p);
      s3_side_in     = s2_side_ff;
      s3_side_in.sat = s2_side_ff.sat || (sq_c.sat &&
                       ((s2_side_ff.op == OP_LOSS && s2_side_ff.lt && !s2_side_ff.ge) ||
                        s2_side_ff.op == OP_CONJ));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_side_ff <= s3_side_in;
         s3_sq_ff   <= sq_c.val;
         s3_num_ff  <= s2_num_ff;
         s3_den_ff  <= s2_den_ff;
      end
   end

   // (delta/2) * p^2 for the conjugate, registered at the divider input
   always_comb begin
      m4_c            = smul(half_w, s3_sq_ff);
      div_side_in     = s3_side_ff;
      div_side_in.m4  = m4_c.val;
      div_side_in.sat = s3_side_ff.sat || (s3_side_ff.op == OP_CONJ && m4_c.sat);
      div_num_in      = (s3_side_ff.op == OP_LOSS) ? s3_sq_ff : s3_num_ff;
   end

   shlo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_v     (s3_v_ff),
      .num      (div_num_in),
      .den      (s3_den_ff),
      .in_side  (div_side_in),
      .out_v    (dv_v),
      .out_quo  (dv_quo),
      .out_neg  (dv_neg),
      .out_ovf  (dv_ovf),
      .out_side (dv_side)
   );

   // stage F: select per operation
   always_comb begin
      if (dv_ovf) begin
         dres.val = dv_neg ? MIN_Q : MAX_Q;
         dres.sat = 1'b1;
      end else begin
         dres = to_signed_sat(dv_neg, {16'd0, dv_quo});
      end
      sa_c     = clamp34(ext34(dv_side.p) + ext34(dv_side.m4));
      f_val_in = ZERO_Q;
      f_ood_in = 1'b0;
      f_sat_in = dv_side.sat;

      unique case (dv_side.op)
         OP_LOSS: begin
            if (!dv_side.lt) begin
               f_val_in = ZERO_Q;
            end else if (dv_side.ge) begin
               f_val_in = dv_side.hsub;
            end else begin
               f_val_in = dres.val;
               f_sat_in = dv_side.sat || dres.sat;
            end
         end
         OP_DERIV: begin
            if (dv_side.gt) begin
               f_val_in = ZERO_Q;
            end else if (dv_side.lt2) begin
               f_val_in = NEG_ONE_Q;
            end else begin
               f_val_in = dres.val;
               f_sat_in = dv_side.sat || dres.sat;
            end
         end
         OP_CONJ: begin
            f_val_in = sa_c.val;
            f_sat_in = dv_side.sat || sa_c.sat;
            f_ood_in = (dv_side.p < NEG_ONE_Q) || (dv_side.p > ZERO_Q);
         end
         OP_PROX: begin
            f_sat_in = dv_side.sat || dres.sat;
            if (dres.val > ZERO_Q) begin
               f_val_in = ZERO_Q;
            end else if (dres.val < NEG_ONE_Q) begin
               f_val_in = NEG_ONE_Q;
            end else begin
               f_val_in = dres.val;
            end
         end
         default: begin
            f_val_in = ZERO_Q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (adv) begin
         f_v_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_op_ff  <= dv_side.op;
         f_y_ff   <= dv_side.y;
         f_val_ff <= f_val_in;
         f_ood_ff <= f_ood_in;
         f_sat_ff <= f_sat_in;
      end
   end

   // output stage: label * clamped quotient for the prox
   always_comb begin
      gm_c = smul(f_y_ff, f_val_ff);
      if (f_op_ff == OP_PROX) begin
         g_val_in = gm_c.val;
         g_sat_in = f_sat_ff || gm_c.sat;
      end else begin
         g_val_in = f_val_ff;
         g_sat_in = f_sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (adv) begin
         g_v_ff <= f_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_op_ff  <= f_op_ff;
         g_val_ff <= g_val_in;
         g_ood_ff <= f_ood_ff;
         g_sat_ff <= g_sat_in;
      end
   end

   assign rsp.valid         = g_v_ff;
   assign rsp.result_value  = g_val_ff;
   assign rsp.out_of_domain = g_ood_ff;
   assign rsp.saturated     = g_sat_ff;

`ifndef SYNTHESIS
   a_ood_conj_only: assert property (@(posedge clock) disable iff (reset)
      (g_v_ff && g_ood_ff) |-> (g_op_ff == OP_CONJ))
      else $error("out_of_domain set on a non-conjugate result");

   a_deriv_nonpos: assert property (@(posedge clock) disable iff (reset)
      (g_v_ff && g_op_ff == OP_DERIV) |-> (g_val_ff <= ZERO_Q))
      else $error("derivative result is positive");

   a_loss_nonneg: assert property (@(posedge clock) disable iff (reset)
      (g_v_ff && g_op_ff == OP_LOSS) |-> (g_val_ff >= ZERO_Q))
      else $error("loss result is negative");
`endif

endmodule

// ===== hw/rtl/smoothed_hinge_loss_ops_top.sv =====
// Top level: config registers, front end, item queue and arithmetic back end.
// Throughput: one item per cycle, set by the 32-stage pipelined divider and
// the fully pipelined multiply stages; the back end stalls only on rsp backpressure.
// Reset: synchronous, active high; clears all valid bits and queue pointers,
// smoothing_width and prox_step return to 1.0 (65536).
module smoothed_hinge_loss_ops_top
   import shlo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   shlo_req_if.sink              req_chan,
   shlo_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CFG_W-1:0] delta_ff;
   logic [CFG_W-1:0] sigma_ff;
   logic             csr_wr;
   csr_index_type    csr_idx;

   logic     q_full;
   logic     q_push;
   item_type q_item;
   logic     q_pop;
   item_type q_head;
   logic     q_head_valid;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = csr_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= SMOOTHING_RESET;
         sigma_ff <= PROX_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SMOOTHING_WIDTH: delta_ff <= pwdata[CFG_W-1:0];
            REG_PROX_STEP:       sigma_ff <= pwdata[CFG_W-1:0];
            default:             delta_ff <= delta_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SMOOTHING_WIDTH: prdata = {1'b0, delta_ff};
         REG_PROX_STEP:       prdata = {1'b0, sigma_ff};
         default:             prdata = '0;
      endcase
   end

   shlo_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (q_item)
   );

   shlo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid)
   );

   shlo_back u_back (
      .clock      (clock),
      .reset      (reset),
      .delta      (delta_ff),
      .sigma      (sigma_ff),
      .head       (q_head),
      .head_valid (q_head_valid),
      .head_pop   (q_pop),
      .rsp        (rsp_chan)
   );

endmodule
